// ===== sv/error_diffusion_dither_assert.svh =====
// Assertion macros for the error diffusion dither checker.
`ifndef ERROR_DIFFUSION_DITHER_ASSERT_SVH
`define ERROR_DIFFUSION_DITHER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define EDD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edd: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define EDD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edd: next-cycle check failed");

`endif

// ===== sv/edd_pkg.sv =====
// Types and constants for the error diffusion dither block.
`timescale 1ns / 1ps
`default_nettype none

package edd_pkg;

  localparam int MODE_W     = 2;
  localparam int PIX_W      = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 11;
  localparam int LEVEL_W    = 3;
  localparam int ERR_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [PIX_W-1:0] SAT_MAX   = 8'hFF;
  localparam logic [PIX_W-1:0] MASK_BW   = 8'h80;
  localparam logic [PIX_W-1:0] MASK_GRAY = 8'hE0;
  localparam logic [ROW_W-1:0] ROW_WIDTH_RST = 11'd1024;

  typedef enum logic [MODE_W-1:0] {
    MODE_PIXEL = 2'd0,
    MODE_SWAP  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISPLAY_MODE = 1'd0,
    REG_ROW_WIDTH    = 1'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PX_READ,
    S_PX_QUANT,
    S_PX_UPD_A,
    S_PX_UPD_B,
    S_PX_UPD_C,
    S_EMIT,
    S_SWAP
  } state_t;

  typedef struct packed {
    logic capture;
    logic sweep_start;
    logic px_quant;
    logic upd_a;
    logic upd_b;
    logic upd_c;
    logic copy_run;
    logic zero_run;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic copy_done;
    logic zero_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/edd_datapath.sv =====
// Datapath: line stores, quantizer, error spread and row sweeps.
`timescale 1ns / 1ps
`default_nettype none

module edd_datapath
  import edd_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat,
  input  wire logic [PIX_W-1:0]      pixel,
  input  wire logic [COL_W-1:0]      column,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic [LEVEL_W-1:0]         level
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
  localparam logic [CNT_W-1:0] ZERO_LIM = CNT_W'(MAX_WIDTH);

  logic [PIX_W-1:0]   cur_mem [MAX_WIDTH];
  logic [PIX_W-1:0]   nxt_mem [MAX_WIDTH];

  logic               cur_we, nxt_we;
  logic [ADDR_W-1:0]  cur_waddr, nxt_waddr, cur_raddr, nxt_raddr;
  logic [PIX_W-1:0]   cur_wdata, nxt_wdata;
  logic [PIX_W-1:0]   cur_rdata, nxt_rdata;

  logic               display_mode;
  logic [ROW_W-1:0]   row_width;

  logic [PIX_W-1:0]   pix_q;
  logic [COL_W-1:0]   col_q;
  logic [ERR_W-1:0]   err_q;
  logic [LEVEL_W-1:0] lvl_hold;

  logic [CNT_W-1:0]   sweep_idx;
  logic               wr_pend;
  logic [ADDR_W-1:0]  wr_addr;

  logic [COL_W:0]     colp1;
  logic [COL_W-1:0]   colm1;
  logic [ADDR_W-1:0]  col_addr, colp1_addr, colm1_addr;
  logic               col_ok, right_ok, left_ok;

  logic [PIX_W-1:0]   px_eff, carried, oldp, newp, diff;
  logic [PIX_W:0]     sum;
  logic [ERR_W-1:0]   err_next;
  logic [9:0]         prod7, prod5, prod3;
  logic [PIX_W-1:0]   share7, share5, share3, share1;

  logic [CNT_W-1:0]   copy_lim;
  logic               copy_more, zero_more;

  // column neighbors and range checks
  assign colp1      = {1'b0, col_q} + 1'b1;
  assign colm1      = col_q - 1'b1;
  assign col_addr   = ADDR_W'(col_q);
  assign colp1_addr = ADDR_W'(colp1);
  assign colm1_addr = ADDR_W'(colm1);
  assign col_ok     = 32'(col_q) < MAX_WIDTH;
  assign right_ok   = (colp1 < row_width) && (32'(colp1) < MAX_WIDTH);
  assign left_ok    = (col_q != '0) && (32'(col_q) <= MAX_WIDTH);

  // quantizer
  always_comb begin
    px_eff   = display_mode ? {1'b0, pix_q[PIX_W-1:1]} : pix_q;
    carried  = col_ok ? cur_rdata : '0;
    sum      = {1'b0, carried} + {1'b0, px_eff};
    oldp     = sum[PIX_W] ? SAT_MAX : sum[PIX_W-1:0];
    newp     = oldp & (display_mode ? MASK_BW : MASK_GRAY);
    diff     = oldp - newp;
    err_next = diff[ERR_W-1:0];
  end

  assign prod7  = 10'(err_q) * 10'd7;
  assign prod5  = 10'(err_q) * 10'd5;
  assign prod3  = 10'(err_q) * 10'd3;
  assign share7 = PIX_W'(prod7 >> 4);
  assign share5 = PIX_W'(prod5 >> 4);
  assign share3 = PIX_W'(prod3 >> 4);
  assign share1 = PIX_W'(err_q >> 4);

  // sweep limits
  assign copy_lim  = (32'(row_width) < MAX_WIDTH) ? CNT_W'(row_width) : ZERO_LIM;
  assign copy_more = sweep_idx < copy_lim;
  assign zero_more = sweep_idx < ZERO_LIM;

  assign stat.copy_done = !copy_more && !wr_pend;
  assign stat.zero_done = !zero_more;

  // store port steering
  always_comb begin
    cur_we    = 1'b0;
    cur_waddr = '0;
    cur_wdata = '0;
    cur_raddr = col_addr;
    nxt_we    = 1'b0;
    nxt_waddr = '0;
    nxt_wdata = '0;
    nxt_raddr = col_addr;
    if (cmd.px_quant) begin
      cur_raddr = colp1_addr;
      nxt_raddr = colm1_addr;
    end
    if (cmd.upd_a) begin
      cur_we    = right_ok;
      cur_waddr = colp1_addr;
      cur_wdata = cur_rdata + share7;
      nxt_we    = left_ok;
      nxt_waddr = colm1_addr;
      nxt_wdata = nxt_rdata + share3;
      nxt_raddr = col_addr;
    end
    if (cmd.upd_b) begin
      nxt_we    = col_ok;
      nxt_waddr = col_addr;
      nxt_wdata = nxt_rdata + share5;
      nxt_raddr = colp1_addr;
    end
    if (cmd.upd_c) begin
      nxt_we    = right_ok;
      nxt_waddr = colp1_addr;
      nxt_wdata = nxt_rdata + share1;
    end
    if (cmd.copy_run) begin
      nxt_raddr = sweep_idx[ADDR_W-1:0];
      cur_we    = wr_pend;
      cur_waddr = wr_addr;
      cur_wdata = nxt_rdata;
      nxt_we    = wr_pend;
      nxt_waddr = wr_addr;
      nxt_wdata = '0;
    end
    if (cmd.zero_run) begin
      cur_we    = zero_more;
      cur_waddr = sweep_idx[ADDR_W-1:0];
      cur_wdata = '0;
      nxt_we    = zero_more;
      nxt_waddr = sweep_idx[ADDR_W-1:0];
      nxt_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[cur_waddr] <= cur_wdata;
    end
    cur_rdata <= cur_mem[cur_raddr];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      nxt_mem[nxt_waddr] <= nxt_wdata;
    end
    nxt_rdata <= nxt_mem[nxt_raddr];
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode <= 1'b0;
      row_width    <= ROW_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DISPLAY_MODE: display_mode <= cfg_data[0];
        REG_ROW_WIDTH:    row_width    <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_idx <= '0;
      wr_pend   <= 1'b0;
    end else if (cmd.sweep_start) begin
      sweep_idx <= '0;
      wr_pend   <= 1'b0;
    end else if (cmd.copy_run) begin
      if (copy_more) begin
        sweep_idx <= sweep_idx + 1'b1;
      end
      wr_pend <= copy_more;
    end else if (cmd.zero_run && zero_more) begin
      sweep_idx <= sweep_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_run) begin
      wr_addr <= sweep_idx[ADDR_W-1:0];
    end
    if (cmd.capture) begin
      pix_q <= pixel;
      col_q <= column;
    end
    if (cmd.px_quant) begin
      err_q    <= err_next;
      lvl_hold <= newp[PIX_W-1 -: LEVEL_W];
    end
    if (cmd.load_out) begin
      level <= lvl_hold;
    end
  end

endmodule

`default_nettype wire

// ===== sv/edd_ctrl.sv =====
// Controller: sequences pixel updates, row sweeps and the result word.
`timescale 1ns / 1ps
`default_nettype none

module edd_ctrl
  import edd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire logic [MODE_W-1:0] mode,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output dp_cmd_t                cmd,
  input  wire dp_stat_t          stat
);

  state_t state, state_next;
  logic   result_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next        = state;
    result_valid_next = result_valid && !result_ready;
    cmd               = '0;
    item_ready        = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.zero_run = 1'b1;
        if (stat.zero_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          unique case (mode)
            MODE_PIXEL: begin
              cmd.capture = 1'b1;
              state_next  = S_PX_READ;
            end
            MODE_SWAP: begin
              cmd.sweep_start = 1'b1;
              state_next      = S_SWAP;
            end
            MODE_CLEAR: begin
              cmd.sweep_start = 1'b1;
              state_next      = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_PX_READ: begin
        state_next = S_PX_QUANT;
      end
      S_PX_QUANT: begin
        cmd.px_quant = 1'b1;
        state_next   = S_PX_UPD_A;
      end
      S_PX_UPD_A: begin
        cmd.upd_a  = 1'b1;
        state_next = S_PX_UPD_B;
      end
      S_PX_UPD_B: begin
        cmd.upd_b  = 1'b1;
        state_next = S_PX_UPD_C;
      end
      S_PX_UPD_C: begin
        cmd.upd_c  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!result_valid || result_ready) begin
          cmd.load_out      = 1'b1;
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      S_SWAP: begin
        cmd.copy_run = 1'b1;
        if (stat.copy_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/error_diffusion_dither.sv =====
// Top level of the Floyd-Steinberg error diffusion dither block.
//
// Streams 8-bit luminance pixels and returns one 3-bit level word per pixel
// word; swap and clear words give no result. A pixel steps through the read,
// quantize, update A, update B, update C and emit states before the next
// ready, set by the single read and single write port of each line store
// (one read-modify-write per spread target), and stays longer in emit while
// the previous level still waits at the output. A row swap copies one store
// entry per cycle, min(row_width, MAX_WIDTH) entries in all; a clear zeroes
// all MAX_WIDTH entries of both stores. After reset a clearing pass runs
// with item_ready low. The result register lets the next word be accepted
// while a level still waits. cfg_ready is always high; write registers only
// while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module error_diffusion_dither
  import edd_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire logic [MODE_W-1:0]     mode,
  input  wire logic [PIX_W-1:0]      pixel,
  input  wire logic [COL_W-1:0]      column,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output logic [LEVEL_W-1:0]         level,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  edd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .mode         (mode),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .stat         (stat)
  );

  edd_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .pixel     (pixel),
    .column    (column),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .level     (level)
  );

endmodule

`default_nettype wire

// ===== sv/edd_checker.sv =====
// Port-level checker for the error diffusion dither block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "error_diffusion_dither_assert.svh"

module edd_checker
  import edd_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               item_valid,
  input wire logic               item_ready,
  input wire logic [MODE_W-1:0]  mode,
  input wire logic               result_valid,
  input wire logic               result_ready,
  input wire logic [LEVEL_W-1:0] level
);

  `EDD_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(level))
  `EDD_ASSERT_IMP(a_busy_after_reset, $past(rst), !item_ready)
  `EDD_ASSERT_IMP(a_pixel_busy, item_valid && item_ready && mode == MODE_PIXEL, ##6 !item_ready)
  `EDD_ASSERT_IMP(a_result_after_work, $rose(result_valid), $past(!item_ready))

endmodule

bind error_diffusion_dither edd_checker u_checker (.*);

`default_nettype wire
